@@ hdl/can2a_pkg.sv @@
// ----------------------------------------------------------------------------
// can2a_pkg
// Shared types and constants for the CAN frame to text record serializer.
// ----------------------------------------------------------------------------
package can2a_pkg;

	localparam int ID_W       = 29;
	localparam int DLC_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int DATA_BYTES = 8;
	localparam int IDX_W      = $clog2(DATA_BYTES);

	// Holds nine times ten to the eighth, the largest digit weight multiple.
	localparam int MULT_W = 40;

	localparam logic [DLC_W-1:0] MAX_LEN = DLC_W'(DATA_BYTES);

	localparam logic [BYTE_W-1:0] ASCII_STD_DATA = 8'h74;
	localparam logic [BYTE_W-1:0] ASCII_STD_RTR  = 8'h72;
	localparam logic [BYTE_W-1:0] ASCII_EXT_DATA = 8'h54;
	localparam logic [BYTE_W-1:0] ASCII_EXT_RTR  = 8'h52;
	localparam logic [BYTE_W-1:0] ASCII_ZERO     = 8'h30;

	typedef struct packed {
		logic                                is_extended;
		logic                                is_remote;
		logic [ID_W-1:0]                     identifier;
		logic [DLC_W-1:0]                    dlc;
		logic [DATA_BYTES-1:0][BYTE_W-1:0]   data;
	} frame_t;

endpackage

@@ hdl/can2a_in_reg.sv @@
// ----------------------------------------------------------------------------
// can2a_in_reg
// Input holding register that takes the next frame while a record streams.
// ----------------------------------------------------------------------------
module can2a_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	output logic             frame_stall,
	input  can2a_pkg::frame_t frame_d,
	input  logic             take,
	output logic             hold_valid,
	output can2a_pkg::frame_t hold_frame
);

	logic              hold_valid_q;
	can2a_pkg::frame_t frame_q;
	logic              accept;

	assign frame_stall = hold_valid_q && !take;
	assign accept      = frame_valid && !frame_stall;
	assign hold_valid  = hold_valid_q;
	assign hold_frame  = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
		end else if (take) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= frame_d;
		end
	end

endmodule

@@ hdl/can2a_digit.sv @@
// ----------------------------------------------------------------------------
// can2a_digit
// Extracts one decimal digit of weight ten to the k from the remainder.
// ----------------------------------------------------------------------------
module can2a_digit #(
	parameter int NUM_W = 9
) (
	input  logic [can2a_pkg::ID_W-1:0]  rem,
	input  logic [$clog2(NUM_W)-1:0]    k,
	output logic [3:0]                  digit,
	output logic [can2a_pkg::ID_W-1:0]  rem_next
);

	localparam int MW = can2a_pkg::MULT_W;

	function automatic logic [63:0] pow10(input int e);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < e; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	logic [MW-1:0] mult_tab [NUM_W][10];
	logic [MW-1:0] rem_ext;
	logic [MW-1:0] diff;

	for (genvar g = 0; g < NUM_W; g++) begin : g_row
		for (genvar m = 0; m < 10; m++) begin : g_col
			assign mult_tab[g][m] = MW'(64'(m) * pow10(g));
		end
	end

	assign rem_ext = {{(MW - can2a_pkg::ID_W){1'b0}}, rem};

	always_comb begin
		digit = 4'd0;
		for (int m = 1; m < 10; m++) begin
			if (rem_ext >= mult_tab[k][m]) begin
				digit = 4'(m);
			end
		end
	end

	assign diff     = rem_ext - mult_tab[k][digit];
	assign rem_next = diff[can2a_pkg::ID_W-1:0];

endmodule

@@ hdl/can2a_serializer.sv @@
// ----------------------------------------------------------------------------
// can2a_serializer
// Walks one frame through its record and loads one byte per cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module can2a_serializer #(
	parameter int STD_ID_DIGITS = 4,
	parameter int EXT_ID_DIGITS = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         hold_valid,
	input  can2a_pkg::frame_t            hold_frame,
	output logic                         take,
	output logic                         byte_valid,
	input  logic                         byte_stall,
	output logic [can2a_pkg::BYTE_W-1:0] out_byte,
	output logic                         last_byte
);

	localparam int K_W = $clog2(EXT_ID_DIGITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TYPE  = 3'd1;
	localparam logic [2:0] ST_DIGIT = 3'd2;
	localparam logic [2:0] ST_LEN   = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;

	logic [2:0]                                          state_q;
	logic                                                ext_q;
	logic                                                remote_q;
	logic [can2a_pkg::ID_W-1:0]                          rem_q;
	logic [K_W-1:0]                                      k_q;
	logic [can2a_pkg::DLC_W-1:0]                         len_q;
	logic [can2a_pkg::IDX_W-1:0]                         data_idx_q;
	logic [can2a_pkg::DATA_BYTES-1:0][can2a_pkg::BYTE_W-1:0] data_q;

	logic                         out_valid_q;
	logic [can2a_pkg::BYTE_W-1:0] out_byte_q;
	logic                         last_q;

	logic                         out_free;
	logic                         adv;
	logic [can2a_pkg::BYTE_W-1:0] byte_d;
	logic                         last_d;
	logic [3:0]                   digit;
	logic [can2a_pkg::ID_W-1:0]   rem_next;
	logic [can2a_pkg::DLC_W-1:0]  len_clamp;
	logic [can2a_pkg::ID_W-1:0]   id_sel;

	can2a_digit #(
		.NUM_W(EXT_ID_DIGITS)
	) u_digit (
		.rem      (rem_q),
		.k        (k_q),
		.digit    (digit),
		.rem_next (rem_next)
	);

	assign out_free = !out_valid_q || !byte_stall;
	assign adv      = (state_q != ST_IDLE) && out_free;
	assign take     = (state_q == ST_IDLE) || (adv && last_d);

	assign len_clamp = (hold_frame.dlc > can2a_pkg::MAX_LEN) ? can2a_pkg::MAX_LEN
		: hold_frame.dlc;
	assign id_sel = hold_frame.is_extended ? hold_frame.identifier
		: {{(can2a_pkg::ID_W - 11){1'b0}}, hold_frame.identifier[10:0]};

	always_comb begin
		byte_d = '0;
		last_d = 1'b0;
		unique case (state_q)
			ST_TYPE: begin
				if (ext_q) begin
					byte_d = remote_q ? can2a_pkg::ASCII_EXT_RTR : can2a_pkg::ASCII_EXT_DATA;
				end else begin
					byte_d = remote_q ? can2a_pkg::ASCII_STD_RTR : can2a_pkg::ASCII_STD_DATA;
				end
			end
			ST_DIGIT: begin
				byte_d = can2a_pkg::ASCII_ZERO + {4'd0, digit};
			end
			ST_LEN: begin
				byte_d = can2a_pkg::ASCII_ZERO + {4'd0, len_q};
				last_d = remote_q || (len_q == '0);
			end
			ST_DATA: begin
				byte_d = data_q[data_idx_q];
				last_d = ((can2a_pkg::DLC_W'(data_idx_q) + 4'd1) == len_q);
			end
			default: begin
				byte_d = '0;
				last_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (take) begin
			state_q <= hold_valid ? ST_TYPE : ST_IDLE;
		end else if (adv) begin
			unique case (state_q)
				ST_TYPE:  state_q <= ST_DIGIT;
				ST_DIGIT: state_q <= (k_q == '0) ? ST_LEN : ST_DIGIT;
				ST_LEN:   state_q <= ST_DATA;
				ST_DATA:  state_q <= ST_DATA;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ext_q      <= hold_frame.is_extended;
			remote_q   <= hold_frame.is_remote;
			rem_q      <= id_sel;
			k_q        <= hold_frame.is_extended ? K_W'(EXT_ID_DIGITS - 1)
				: K_W'(STD_ID_DIGITS - 1);
			len_q      <= len_clamp;
			data_idx_q <= '0;
			data_q     <= hold_frame.data;
		end else if (adv) begin
			if (state_q == ST_DIGIT) begin
				rem_q <= rem_next;
				k_q   <= k_q - K_W'(1);
			end
			if (state_q == ST_DATA) begin
				data_idx_q <= data_idx_q + can2a_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= byte_d;
			last_q     <= last_d;
		end
	end

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_q;

	a_len_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (len_q <= can2a_pkg::MAX_LEN))
		else $error("Stored length exceeds the payload limit.");

	a_remote_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> !remote_q)
		else $error("Remote frame entered the payload phase.");

	a_data_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> ({1'b0, data_idx_q} < len_q))
		else $error("Payload index ran past the length.");

	a_last_ends_record: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_d) |=> ((state_q == ST_IDLE) || (state_q == ST_TYPE)))
		else $error("Record did not end after its last byte.");

endmodule

@@ hdl/can_frame_to_ascii_record_top.sv @@
// ----------------------------------------------------------------------------
// can_frame_to_ascii_record_top
// Turns each received CAN frame into its text record, presented one byte at a time.
// ----------------------------------------------------------------------------
// After its frame is taken, a record starts in the serializer state register and its
// first byte is then loaded into the output register. Throughput: one byte per cycle
// while byte_stall is low; a record is 6 to 19 bytes at default digit counts, and the
// next frame waits in the input register so records follow without gaps.
// Reset: arst_n clears the valid flags and the serializer state; data is kept.
module can_frame_to_ascii_record_top #(
	parameter int STD_ID_DIGITS = 4,
	parameter int EXT_ID_DIGITS = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         frame_valid,
	output logic                         frame_stall,
	input  logic                         is_extended,
	input  logic                         is_remote,
	input  logic [can2a_pkg::ID_W-1:0]   identifier,
	input  logic [can2a_pkg::DLC_W-1:0]  dlc,
	input  logic [7:0]                   data_byte0,
	input  logic [7:0]                   data_byte1,
	input  logic [7:0]                   data_byte2,
	input  logic [7:0]                   data_byte3,
	input  logic [7:0]                   data_byte4,
	input  logic [7:0]                   data_byte5,
	input  logic [7:0]                   data_byte6,
	input  logic [7:0]                   data_byte7,
	output logic                         byte_valid,
	input  logic                         byte_stall,
	output logic [can2a_pkg::BYTE_W-1:0] out_byte,
	output logic                         last_byte
);

	can2a_pkg::frame_t frame_d;
	can2a_pkg::frame_t hold_frame;
	logic              hold_valid;
	logic              take;

	assign frame_d.is_extended = is_extended;
	assign frame_d.is_remote   = is_remote;
	assign frame_d.identifier  = identifier;
	assign frame_d.dlc         = dlc;
	assign frame_d.data        = {data_byte7, data_byte6, data_byte5, data_byte4,
		data_byte3, data_byte2, data_byte1, data_byte0};

	can2a_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_d     (frame_d),
		.take        (take),
		.hold_valid  (hold_valid),
		.hold_frame  (hold_frame)
	);

	can2a_serializer #(
		.STD_ID_DIGITS(STD_ID_DIGITS),
		.EXT_ID_DIGITS(EXT_ID_DIGITS)
	) u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold_valid (hold_valid),
		.hold_frame (hold_frame),
		.take       (take),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule
